[design/sdec2a_pkg.sv]
// Shared types and constants for the signed decimal to ASCII converter.
// Used by sdec2a_cell.sv and signed_decimal_to_ascii.sv; depends on nothing.
package sdec2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int LEN_W      = 4;
    localparam int BITCNT_W   = 5;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    // Control for the row of digit cells.
    typedef struct packed {
        logic clear;   // load zero
        logic dabble;  // add-3 adjust and shift in one binary bit
        logic dshift;  // take the digit of the lower neighbor
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_ALIGN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

endpackage

[design/signed_decimal_to_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, one character per strobe beat; uses sdec2a_pkg.
// The first character follows the accept, the double-dabble conversion and the alignment, which
// runs longer for each leading zero digit skipped; a minus sign does not delay it.
// A new value is taken only once the last character of the previous one has been sent: the
// accept, the double-dabble cell row, leading-zero alignment and shift-out (with a sign first).
// Reset (i_rst_n low, synchronous) returns to idle and drops the strobe; results cannot stall.
module signed_decimal_to_ascii (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sdec2a_pkg::VALUE_W-1:0] i_value,
    output logic                                o_strobe,
    output logic [sdec2a_pkg::CHAR_W-1:0]       o_character,
    output logic                                o_last,
    output logic [sdec2a_pkg::LEN_W-1:0]        o_length
);

    localparam int N  = sdec2a_pkg::NUM_DIGITS;
    localparam int DW = sdec2a_pkg::DIGIT_W;

    sdec2a_pkg::t_state    r_state, n_state;
    sdec2a_pkg::t_cell_ctl w_ctl;

    logic [sdec2a_pkg::VALUE_W-1:0]  r_mag, n_mag;
    logic [sdec2a_pkg::BITCNT_W-1:0] r_bitcnt, n_bitcnt;
    logic [sdec2a_pkg::LEN_W-1:0]    r_cnt, n_cnt;
    logic [sdec2a_pkg::LEN_W-1:0]    r_len, n_len;
    logic                            r_neg, n_neg;
    logic                            r_sign, n_sign;

    logic                            n_strobe, n_last;
    logic [sdec2a_pkg::CHAR_W-1:0]   n_character;
    logic [sdec2a_pkg::LEN_W-1:0]    n_length;

    logic [N-1:0]    w_carry;
    logic [DW-1:0]   w_digit [N];
    logic [DW-1:0]   w_top;
    logic            w_accept;

    assign busy     = (r_state != sdec2a_pkg::ST_IDLE);
    assign w_accept = start && !busy;
    assign w_top    = w_digit[N-1];

    // Row of digit cells: binary bits and digits both move toward the top cell.
    assign w_carry[0] = r_mag[sdec2a_pkg::VALUE_W-1];

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_low
            sdec2a_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_carry[g]),
                .i_digit ('0),
                .o_bit   (w_carry[g+1]),
                .o_digit (w_digit[g])
            );
        end else if (g == N-1) begin : g_top
            sdec2a_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_carry[g]),
                .i_digit (w_digit[g-1]),
                .o_bit   (),
                .o_digit (w_digit[g])
            );
        end else begin : g_mid
            sdec2a_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_carry[g]),
                .i_digit (w_digit[g-1]),
                .o_bit   (w_carry[g+1]),
                .o_digit (w_digit[g])
            );
        end
    end

    // Sequencer: convert, skip leading zeros, then send sign and digits.
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_bitcnt    = r_bitcnt;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_neg       = r_neg;
        n_sign      = r_sign;
        w_ctl       = '0;
        n_strobe    = 1'b0;
        n_character = o_character;
        n_last      = 1'b0;
        n_length    = '0;

        case (r_state)
            sdec2a_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_neg    = i_value[sdec2a_pkg::VALUE_W-1];
                    n_mag    = i_value[sdec2a_pkg::VALUE_W-1] ?
                               (~i_value + 1'b1) : i_value;
                    n_bitcnt = '1;
                    n_cnt    = sdec2a_pkg::LEN_W'(N);
                    w_ctl.clear = 1'b1;
                    n_state  = sdec2a_pkg::ST_CONV;
                end
            end
            sdec2a_pkg::ST_CONV: begin
                w_ctl.dabble = 1'b1;
                n_mag        = {r_mag[sdec2a_pkg::VALUE_W-2:0], 1'b0};
                n_bitcnt     = r_bitcnt - 1'b1;
                if (r_bitcnt == '0) begin
                    n_state = sdec2a_pkg::ST_ALIGN;
                end
            end
            sdec2a_pkg::ST_ALIGN: begin
                if (w_top == '0 && r_cnt > 1) begin
                    w_ctl.dshift = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end else begin
                    n_len   = r_cnt + {{(sdec2a_pkg::LEN_W-1){1'b0}}, r_neg};
                    n_sign  = r_neg;
                    n_state = sdec2a_pkg::ST_EMIT;
                end
            end
            sdec2a_pkg::ST_EMIT: begin
                n_strobe = 1'b1;
                if (r_sign) begin
                    n_character = sdec2a_pkg::CHAR_MINUS;
                    n_sign      = 1'b0;
                end else begin
                    n_character  = sdec2a_pkg::CHAR_ZERO +
                                   {{(sdec2a_pkg::CHAR_W-DW){1'b0}}, w_top};
                    w_ctl.dshift = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                    if (r_cnt == 1) begin
                        n_last   = 1'b1;
                        n_length = r_len;
                        n_state  = sdec2a_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sdec2a_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sdec2a_pkg::ST_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= n_strobe;
        end
    end

    // Working and output beat registers.
    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_bitcnt    <= n_bitcnt;
        r_cnt       <= n_cnt;
        r_len       <= n_len;
        r_neg       <= n_neg;
        r_sign      <= n_sign;
        o_character <= n_character;
        o_last      <= n_last;
        o_length    <= n_length;
    end

endmodule

[design/sdec2a_cell.sv]
// One BCD digit cell of the double-dabble row.
// Depends on sdec2a_pkg for the digit width and the cell control struct.
module sdec2a_cell (
    input  logic                           i_clk,
    input  sdec2a_pkg::t_cell_ctl          i_ctl,
    input  logic                           i_bit,
    input  logic [sdec2a_pkg::DIGIT_W-1:0] i_digit,
    output logic                           o_bit,
    output logic [sdec2a_pkg::DIGIT_W-1:0] o_digit
);

    logic [sdec2a_pkg::DIGIT_W-1:0] r_digit;
    logic [sdec2a_pkg::DIGIT_W-1:0] w_adj;

    // Add three when the digit is five or more, so the next doubling carries right.
    always_comb begin
        if (r_digit >= sdec2a_pkg::DABBLE_MIN) begin
            w_adj = r_digit + sdec2a_pkg::DABBLE_ADD;
        end else begin
            w_adj = r_digit;
        end
    end

    assign o_bit   = w_adj[sdec2a_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    // Digit register: clear, shift one bit in, or take the neighbor's digit.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.dabble) begin
            r_digit <= {w_adj[sdec2a_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctl.dshift) begin
            r_digit <= i_digit;
        end
    end

endmodule
